/* src/u8dec_pkg.sv */
// u8dec_pkg: shared widths, constants, result type and lead byte decode
// for the utf-8 byte stream decoder; no dependencies
package u8dec_pkg;

    localparam int unsigned ByteW    = 8;
    localparam int unsigned CpW      = 31;
    localparam int unsigned RemW     = 3;
    localparam int unsigned ContBits = 6;

    // longest sequence leaves five following bytes open
    localparam logic [RemW-1:0] MaxRemaining = 3'd5;

    typedef struct packed {
        logic [CpW-1:0] code_point;
        logic           end_of_text;
    } result_t;

    typedef struct packed {
        logic            valid;
        logic [RemW-1:0] remaining;
        logic [CpW-1:0]  seed;
    } lead_t;

    // lead byte of form 11xxxxxx: following byte count and payload bits
    function automatic lead_t decode_lead(input logic [ByteW-1:0] b);
        lead_t lead;
        lead.valid     = 1'b1;
        lead.remaining = '0;
        lead.seed      = '0;
        if (!b[5])
        begin
            lead.remaining = 3'd1;
            lead.seed      = CpW'(b & 8'h1f);
        end
        else if (!b[4])
        begin
            lead.remaining = 3'd2;
            lead.seed      = CpW'(b & 8'h0f);
        end
        else if (!b[3])
        begin
            lead.remaining = 3'd3;
            lead.seed      = CpW'(b & 8'h07);
        end
        else if (!b[2])
        begin
            lead.remaining = 3'd4;
            lead.seed      = CpW'(b & 8'h03);
        end
        else if (!b[1])
        begin
            lead.remaining = MaxRemaining;
            lead.seed      = CpW'(b & 8'h01);
        end
        else
        begin
            // 0xfe and 0xff
            lead.valid = 1'b0;
        end
        return lead;
    endfunction

endpackage

/* src/u8dec_in_stage.sv */
// u8dec_in_stage: input register holding one text byte transaction
// depends on u8dec_pkg
module u8dec_in_stage (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [u8dec_pkg::ByteW-1:0]   text_byte,
    output logic                          item_valid,
    output logic [u8dec_pkg::ByteW-1:0]   item_byte,
    input  logic                          item_ready
);

    logic                        valid_reg;
    logic                        valid_next;
    logic [u8dec_pkg::ByteW-1:0] byte_reg;

    assign in_ready   = !valid_reg || item_ready;
    assign item_valid = valid_reg;
    assign item_byte  = byte_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (item_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= text_byte;
        end
    end

endmodule

/* src/u8dec_core.sv */
// u8dec_core: sequence state and one-byte decode step
// depends on u8dec_pkg
module u8dec_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    input  logic [u8dec_pkg::ByteW-1:0]   item_byte,
    output logic                          item_ready,
    output logic                          res_valid,
    output u8dec_pkg::result_t            res,
    input  logic                          res_ready
);

    logic [u8dec_pkg::RemW-1:0] remaining_reg;
    logic [u8dec_pkg::RemW-1:0] remaining_next;
    logic [u8dec_pkg::CpW-1:0]  acc_reg;
    logic [u8dec_pkg::CpW-1:0]  acc_next;
    logic [u8dec_pkg::CpW-1:0]  shifted;
    logic                       emit;
    logic                       take;
    u8dec_pkg::lead_t           lead;

    assign shifted = {acc_reg[u8dec_pkg::CpW-u8dec_pkg::ContBits-1:0],
                      item_byte[u8dec_pkg::ContBits-1:0]};
    assign lead    = u8dec_pkg::decode_lead(item_byte);

    always_comb
    begin
        emit           = 1'b0;
        remaining_next = remaining_reg;
        acc_next       = acc_reg;
        res            = '0;
        if (remaining_reg != '0)
        begin
            remaining_next = remaining_reg - 3'd1;
            if (remaining_reg == 3'd1)
            begin
                emit           = 1'b1;
                res.code_point = shifted;
                acc_next       = '0;
            end
            else
            begin
                acc_next = shifted;
            end
        end
        else if (item_byte == '0)
        begin
            emit            = 1'b1;
            res.end_of_text = 1'b1;
            acc_next        = '0;
        end
        else if (!item_byte[7])
        begin
            emit           = 1'b1;
            res.code_point = u8dec_pkg::CpW'(item_byte);
        end
        else if (item_byte[6] && lead.valid)
        begin
            acc_next       = lead.seed;
            remaining_next = lead.remaining;
        end
        // stray continuation bytes and 0xfe/0xff leave the state alone
    end

    assign item_ready = !emit || res_ready;
    assign take       = item_valid && item_ready;
    assign res_valid  = item_valid && emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remaining_reg <= '0;
            acc_reg       <= '0;
        end
        else if (take)
        begin
            remaining_reg <= remaining_next;
            acc_reg       <= acc_next;
        end
    end

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        remaining_reg <= u8dec_pkg::MaxRemaining)
        else $error("open sequence count out of range");

    a_last_byte_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && remaining_reg == 3'd1) |-> res_valid)
        else $error("last byte of a sequence gave no result");

    a_eot_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (take && res.end_of_text) |=> (remaining_reg == '0 && acc_reg == '0))
        else $error("end of text did not clear the state");

    a_eot_zero_cp: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.end_of_text) |-> (res.code_point == '0 && remaining_reg == '0))
        else $error("end of text result carries a code point");

endmodule

/* src/u8dec_out_stage.sv */
// u8dec_out_stage: result register toward the output channel
// depends on u8dec_pkg
module u8dec_out_stage (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          res_valid,
    input  u8dec_pkg::result_t            res,
    output logic                          res_ready,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [u8dec_pkg::CpW-1:0]     code_point,
    output logic                          end_of_text
);

    logic               valid_reg;
    logic               valid_next;
    u8dec_pkg::result_t res_reg;

    assign res_ready   = !valid_reg || out_ready;
    assign out_valid   = valid_reg;
    assign code_point  = res_reg.code_point;
    assign end_of_text = res_reg.end_of_text;

    always_comb
    begin
        valid_next = valid_reg;
        if (res_valid && res_ready)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            res_reg <= res;
        end
    end

endmodule

/* src/utf8_byte_stream_decoder_unit.sv */
// utf8_byte_stream_decoder_unit: one text byte per cycle in while the output is not stalled, code points out
// result path: the last byte is registered in u8dec_in_stage, decoded in u8dec_core, registered in u8dec_out_stage
// throughput: one byte per cycle while out_ready does not stall the output; u8dec_core updates its state per byte
// reset: async active low, clears the open sequence count, accumulator and valid flags
// depends on u8dec_pkg, u8dec_in_stage, u8dec_core, u8dec_out_stage
module utf8_byte_stream_decoder_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [u8dec_pkg::ByteW-1:0]   text_byte,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [u8dec_pkg::CpW-1:0]     code_point,
    output logic                          end_of_text
);

    logic                        item_valid;
    logic                        item_ready;
    logic [u8dec_pkg::ByteW-1:0] item_byte;
    logic                        res_valid;
    logic                        res_ready;
    u8dec_pkg::result_t          res;

    u8dec_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .text_byte  (text_byte),
        .item_valid (item_valid),
        .item_byte  (item_byte),
        .item_ready (item_ready)
    );

    u8dec_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_byte  (item_byte),
        .item_ready (item_ready),
        .res_valid  (res_valid),
        .res        (res),
        .res_ready  (res_ready)
    );

    u8dec_out_stage u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .res_valid   (res_valid),
        .res         (res),
        .res_ready   (res_ready),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .code_point  (code_point),
        .end_of_text (end_of_text)
    );

endmodule

/* tb/utf8_byte_stream_decoder_unit_tb.sv */
// utf8_byte_stream_decoder_unit_tb: self-checking testbench for the utf-8 byte stream decoder
// drives text bytes, predicts code points with its own decoder model, checks every result
// depends on u8dec_pkg and utf8_byte_stream_decoder_unit
module utf8_byte_stream_decoder_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned ByteW    = u8dec_pkg::ByteW;
    localparam int unsigned CpW      = u8dec_pkg::CpW;
    localparam int unsigned RemW     = u8dec_pkg::RemW;
    localparam int unsigned ContBits = u8dec_pkg::ContBits;

    typedef u8dec_pkg::result_t result_t;

    typedef enum int
    {
        IdleNone,
        IdleSender,
        IdleReceiver,
        IdleBoth
    } idle_phase_t;

    localparam int unsigned PhaseBytes = 275;
    localparam int unsigned TailCycles = 8;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    logic [ByteW-1:0] text_byte = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    logic [CpW-1:0]   code_point;
    logic             end_of_text;

    // decoder model state
    logic [RemW-1:0]  seq_left = '0;
    logic [CpW-1:0]   cp_acc = '0;
    int unsigned      seq_len = 0;

    result_t          expected_code_points[$];

    int unsigned      send_idle_pct = 0;
    int unsigned      recv_stall_pct = 0;
    int unsigned      error_count = 0;
    int unsigned      bytes_accepted = 0;
    int unsigned      bytes_decoded = 0;
    int unsigned      results_checked = 0;
    int unsigned      eot_seen = 0;
    int unsigned      seq_done[1:6];

    utf8_byte_stream_decoder_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .text_byte   (text_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .code_point  (code_point),
        .end_of_text (end_of_text)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        #5_000_000;
        $display("%0t: timeout, decoder stopped making progress", $time);
        $display("FAIL");
        $finish;
    end

    function automatic int unsigned count_leading_ones(input logic [ByteW-1:0] b);
        int unsigned n;
        n = 0;
        while (n < 8 && b[7-n])
            n++;
        return n;
    endfunction

    // advance the model by one byte; dropped marks bytes the decoder ignores
    function automatic void predict_decode(input logic [ByteW-1:0] b,
                                           output bit has_result,
                                           output result_t res,
                                           output bit dropped);
        int unsigned ones;
        has_result = 1'b0;
        dropped    = 1'b0;
        res        = '0;
        if (seq_left != 0)
        begin
            // following bytes are taken whatever their top two bits are
            cp_acc   = {cp_acc[CpW-ContBits-1:0], b[ContBits-1:0]};
            seq_left = seq_left - 1'b1;
            if (seq_left == 0)
            begin
                has_result     = 1'b1;
                res.code_point = cp_acc;
                cp_acc         = '0;
                seq_done[seq_len]++;
            end
        end
        else if (b == 8'h00)
        begin
            has_result      = 1'b1;
            res.end_of_text = 1'b1;
            cp_acc          = '0;
        end
        else if (!b[7])
        begin
            has_result     = 1'b1;
            res.code_point = CpW'(b);
            seq_done[1]++;
        end
        else if (!b[6])
        begin
            dropped = 1'b1;
        end
        else
        begin
            ones = count_leading_ones(b);
            if (ones > 6)
            begin
                dropped = 1'b1;
            end
            else
            begin
                cp_acc   = CpW'(b & (8'hff >> ones));
                seq_left = RemW'(ones - 1);
                seq_len  = ones;
            end
        end
    endfunction

    function automatic void set_idle_phase(input idle_phase_t phase);
        case (phase)
            IdleNone:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            IdleSender:
            begin
                send_idle_pct  = 78;
                recv_stall_pct = 0;
            end
            IdleReceiver:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 78;
            end
            default:
            begin
                send_idle_pct  = 31;
                recv_stall_pct = 31;
            end
        endcase
    endfunction

    // one input transaction, with random idle cycles ahead of it
    task automatic send_text_byte(input logic [ByteW-1:0] b);
        bit      has_result;
        bit      dropped;
        result_t res;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        text_byte <= b;
        do
            @(posedge clk);
        while (!in_ready);
        predict_decode(b, has_result, res, dropped);
        bytes_accepted++;
        if (!dropped)
            bytes_decoded++;
        if (has_result)
            expected_code_points.push_back(res);
    endtask

    // hold off the sender until every expected code point has come out
    task automatic wait_decoder_drained();
        in_valid <= 1'b0;
        while (expected_code_points.size() != 0)
            @(posedge clk);
        repeat (TailCycles) @(posedge clk);
    endtask

    // well-formed sequence of len bytes; loose lets following bytes take any value
    task automatic send_sequence(input int unsigned len, input bit loose);
        logic [ByteW-1:0] lead;
        if (len == 1)
        begin
            send_text_byte(ByteW'($urandom_range(1, 127)));
        end
        else
        begin
            lead = (8'hff << (8 - len)) | (ByteW'($urandom) & (8'hff >> (len + 1)));
            send_text_byte(lead);
            for (int unsigned i = 1; i < len; i++)
            begin
                if (loose)
                    send_text_byte(ByteW'($urandom));
                else
                    send_text_byte(8'h80 | (ByteW'($urandom) & 8'h3f));
            end
        end
    endtask

    task automatic test_directed_bytes();
        logic [ByteW-1:0] seq[] = '{
            8'h01, 8'h7f, 8'h00,               // ascii extremes and end of text
            8'h80, 8'hbf,                      // stray continuation bytes
            8'hfe, 8'hff,                      // invalid lead bytes
            8'hc2, 8'ha9,                      // two-byte sequence
            8'he2, 8'h82, 8'hac,               // three-byte sequence
            8'hf0, 8'h9f, 8'h98, 8'h80,        // four-byte sequence
            8'hfd, 8'hbf, 8'hbf, 8'hbf, 8'hbf, 8'hbf, // six bytes, all 31 bits set
            8'hc3, 8'h00,                      // zero byte inside a sequence
            8'he1, 8'hff, 8'h41                // unchecked following bytes
        };
        set_idle_phase(IdleNone);
        foreach (seq[i])
            send_text_byte(seq[i]);
        wait_decoder_drained();
    endtask

    task automatic test_random_text(input idle_phase_t phase);
        int unsigned stop_at;
        int unsigned pick;
        set_idle_phase(phase);
        stop_at = bytes_decoded + PhaseBytes;
        while (bytes_decoded < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
                send_sequence($urandom_range(1, 6), 1'b0);
            else if (pick < 80)
                send_sequence($urandom_range(2, 6), 1'b1);
            else if (pick < 85)
                send_text_byte(8'h00);
            else if (pick < 90)
                send_text_byte(8'h80 | (ByteW'($urandom) & 8'h3f));
            else if (pick < 93)
                send_text_byte(8'hfe | ByteW'($urandom_range(1)));
            else
                send_text_byte(ByteW'($urandom));
        end
        wait_decoder_drained();
    endtask

    // result side: random backpressure and check of each output transaction
    initial
    begin
        result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (expected_code_points.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected result code_point=%h end_of_text=%b",
                             $time, code_point, end_of_text);
                end
                else
                begin
                    want = expected_code_points.pop_front();
                    results_checked++;
                    if (want.end_of_text)
                        eot_seen++;
                    if (code_point !== want.code_point)
                    begin
                        error_count++;
                        $display("%0t: code_point expected %h actual %h",
                                 $time, want.code_point, code_point);
                    end
                    if (end_of_text !== want.end_of_text)
                    begin
                        error_count++;
                        $display("%0t: end_of_text expected %b actual %b",
                                 $time, want.end_of_text, end_of_text);
                    end
                end
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin
        foreach (seq_done[i])
            seq_done[i] = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_bytes();
        test_random_text(IdleNone);
        test_random_text(IdleSender);
        test_random_text(IdleReceiver);
        test_random_text(IdleBoth);

        while (expected_code_points.size() != 0)
            @(posedge clk);
        repeat (TailCycles) @(posedge clk);

        $display("covered %0d bytes (%0d decoded), %0d results checked, %0d end-of-text marks",
                 bytes_accepted, bytes_decoded, results_checked, eot_seen);
        $display("sequences by length 1..6: %0d %0d %0d %0d %0d %0d",
                 seq_done[1], seq_done[2], seq_done[3], seq_done[4], seq_done[5],
                 seq_done[6]);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* filelist.f */
src/u8dec_pkg.sv
src/u8dec_in_stage.sv
src/u8dec_core.sv
src/u8dec_out_stage.sv
src/utf8_byte_stream_decoder_unit.sv
tb/utf8_byte_stream_decoder_unit_tb.sv
